@@ rtl/core/pie_pkg.sv @@
// Shared types, codes and reset constants of the power iteration block.
package pie_pkg;

    localparam int DATA_W  = 32;
    localparam int ORDER_W = 5;
    localparam int TOL_W   = 31;
    localparam int PASS_W  = 16;
    localparam int CFG_W   = 31;

    localparam logic [ORDER_W-1:0] ORDER_RESET      = 5'd4;
    localparam logic [TOL_W-1:0]   TOLERANCE_RESET  = 31'd66;
    localparam logic [PASS_W-1:0]  MAX_PASSES_RESET = 16'd1000;

    localparam logic [1:0] OP_LOAD_MATRIX = 2'd0;
    localparam logic [1:0] OP_LOAD_VECTOR = 2'd1;
    localparam logic [1:0] OP_START       = 2'd2;

    localparam logic [1:0] STATUS_CONVERGED  = 2'd0;
    localparam logic [1:0] STATUS_PASS_LIMIT = 2'd1;
    localparam logic [1:0] STATUS_ZERO       = 2'd2;

    localparam logic [1:0] REG_ORDER      = 2'd0;
    localparam logic [1:0] REG_TOLERANCE  = 2'd1;
    localparam logic [1:0] REG_MAX_PASSES = 2'd2;

    typedef enum logic [2:0] {
        S_IDLE,
        S_INJECT,
        S_DRAIN,
        S_CHECK,
        S_DIV,
        S_DECIDE,
        S_EMIT
    } state_t;

    // Writes into one cell: vector element, product element, matrix column entry.
    typedef struct packed {
        logic              vec_we;
        logic [DATA_W-1:0] vec_data;
        logic              prod_we;
        logic [DATA_W-1:0] prod_data;
        logic              mat_we;
        logic [DATA_W-1:0] mat_data;
    } cell_wr_t;

    typedef struct packed {
        logic              start;
        logic [DATA_W-1:0] num;
        logic [DATA_W-1:0] den;
    } div_req_t;

endpackage

@@ rtl/core/pie_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
module pie_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

@@ rtl/core/pie_div.sv @@
// Iterative restoring divider for the normalization (x << FRAC_BITS) / estimate.
module pie_div #(
    parameter int FRAC_BITS = 16
) (
    input  logic             clk,
    input  logic             rst_n,
    input  pie_pkg::div_req_t req,
    output logic             done,
    output logic [31:0]      quo
);
    import pie_pkg::*;

    localparam int DW = DATA_W + FRAC_BITS;
    localparam int CW = $clog2(DW + 1);

    logic [DW-1:0]   dvd_reg, dvd_next;
    logic [DW-1:0]   q_reg, q_next;
    logic [DATA_W:0] rem_reg, rem_next;
    logic [DATA_W-1:0] den_reg, den_next;
    logic            neg_reg, neg_next;
    logic [CW-1:0]   cnt_reg, cnt_next;
    logic            busy_reg, busy_next;
    logic            fin_reg, fin_next;

    logic [DATA_W:0]   rem_sh;
    logic [DATA_W-1:0] num_mag;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            fin_reg  <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            fin_reg  <= fin_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dvd_reg <= dvd_next;
        q_reg   <= q_next;
        rem_reg <= rem_next;
        den_reg <= den_next;
        neg_reg <= neg_next;
    end

    always_comb
    begin
        num_mag   = req.num[DATA_W-1] ? DATA_W'(-req.num) : req.num;
        rem_sh    = {rem_reg[DATA_W-1:0], dvd_reg[DW-1]};
        dvd_next  = dvd_reg;
        q_next    = q_reg;
        rem_next  = rem_reg;
        den_next  = den_reg;
        neg_next  = neg_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        fin_next  = 1'b0;
        if (req.start)
        begin
            dvd_next  = {num_mag, {FRAC_BITS{1'b0}}};
            q_next    = '0;
            rem_next  = '0;
            den_next  = req.den;
            neg_next  = req.num[DATA_W-1];
            cnt_next  = CW'(DW);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            dvd_next = {dvd_reg[DW-2:0], 1'b0};
            if (rem_sh >= {1'b0, den_reg})
            begin
                rem_next = rem_sh - {1'b0, den_reg};
                q_next   = {q_reg[DW-2:0], 1'b1};
            end
            else
            begin
                rem_next = rem_sh;
                q_next   = {q_reg[DW-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CW'(1))
            begin
                busy_next = 1'b0;
                fin_next  = 1'b1;
            end
        end
    end

    always_comb
    begin
        if (!neg_reg)
        begin
            quo = (q_reg > DW'(32'h7FFF_FFFF)) ? 32'h7FFF_FFFF : q_reg[DATA_W-1:0];
        end
        else
        begin
            quo = (q_reg > DW'(32'h8000_0000)) ? 32'h8000_0000 : DATA_W'(-q_reg[DATA_W-1:0]);
        end
    end

    assign done = fin_reg;

    a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
        fin_reg |-> $past(busy_reg))
        else $error("divider finished without running");

    a_no_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg |-> cnt_reg != '0)
        else $error("divider busy with empty count");

    a_count_drops: assert property (@(posedge clk) disable iff (!rst_n)
        (busy_reg && !req.start) |=> (cnt_reg == $past(cnt_reg) - 1'b1))
        else $error("divider count did not step");

endmodule

@@ rtl/core/pie_cell.sv @@
// One cell of the chain: holds a vector element and a matrix column, adds its term.
module pie_cell #(
    parameter int MAX_ORDER = 16,
    parameter int FRAC_BITS = 16
) (
    input  logic                                                  clk,
    input  logic                                                  rst_n,
    input  pie_pkg::cell_wr_t                                     wr,
    input  logic [$clog2(MAX_ORDER)-1:0]                          mat_addr,
    input  logic                                                  active,
    input  logic                                                  tok_valid_in,
    input  logic [$clog2(MAX_ORDER)-1:0]                          tok_row_in,
    input  logic signed [64-FRAC_BITS+$clog2(MAX_ORDER):0]        tok_sum_in,
    output logic                                                  tok_valid_out,
    output logic [$clog2(MAX_ORDER)-1:0]                          tok_row_out,
    output logic signed [64-FRAC_BITS+$clog2(MAX_ORDER):0]        tok_sum_out,
    output logic [31:0]                                           cur,
    output logic [31:0]                                           prod
);
    import pie_pkg::*;

    localparam int IDX_W = $clog2(MAX_ORDER);
    localparam int SUM_W = 64 - FRAC_BITS + IDX_W + 1;

    logic [DATA_W-1:0] cur_reg, prod_reg, ram_rdata;
    logic              v0_reg, v1_reg, v2_reg;
    logic [IDX_W-1:0]  row0_reg, row1_reg, row2_reg;
    logic signed [SUM_W-1:0] sum0_reg, sum1_reg, sum2_reg, sum2_next;
    logic signed [63:0] prod1_reg, prod1_next, term;

    pie_ram #(.WIDTH(DATA_W), .DEPTH(MAX_ORDER)) u_col (
        .clk   (clk),
        .we    (wr.mat_we),
        .waddr (mat_addr),
        .wdata (wr.mat_data),
        .raddr (tok_row_in),
        .rdata (ram_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v0_reg <= 1'b0;
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end
        else
        begin
            v0_reg <= tok_valid_in;
            v1_reg <= v0_reg;
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        row0_reg  <= tok_row_in;
        sum0_reg  <= tok_sum_in;
        row1_reg  <= row0_reg;
        sum1_reg  <= sum0_reg;
        prod1_reg <= prod1_next;
        row2_reg  <= row1_reg;
        sum2_reg  <= sum2_next;
        if (wr.vec_we)
        begin
            cur_reg <= wr.vec_data;
        end
        if (wr.prod_we)
        begin
            prod_reg <= wr.prod_data;
        end
    end

    always_comb
    begin
        prod1_next = $signed(ram_rdata) * $signed(cur_reg);
        // Arithmetic shift gives the floor of the scaled product.
        term       = prod1_reg >>> FRAC_BITS;
        sum2_next  = active ? sum1_reg + SUM_W'(term) : sum1_reg;
    end

    assign tok_valid_out = v2_reg;
    assign tok_row_out   = row2_reg;
    assign tok_sum_out   = sum2_reg;
    assign cur           = cur_reg;
    assign prod          = prod_reg;

endmodule

@@ rtl/core/power_iteration_eigenvalue.sv @@
// Top level: dominant eigenvalue by power iteration over a chain of column cells.
//
// Command channel (cmd_valid/cmd_ready) takes one beat per op: load a matrix
// entry, load a vector entry, or start. In idle, loads are taken one per cycle.
// A start beat runs passes until the estimate settles, the pass cap is hit, or
// the vector goes to zero; cmd_ready stays low while a run is under way.
// Each pass streams n row tokens through MAX_ORDER cells, three stages each,
// then runs n divisions, one at a time, on the shared divider. Pass time is set
// by the chain depth and the bit-serial divider.
// Result channel (res_valid/res_ready) then gives n+1 beats: the estimate with
// is_eigenvalue set, then elements 0..n-1, last on the final one. A stalled
// receiver holds the output register and the block waits in its emit step.
// Reset clears control state and sets order 4, tolerance 66, max_passes 1000;
// matrix and vector contents are undefined until loaded. The configuration
// port (cfg_we, cfg_index, cfg_data) must be written by the user only while no
// run is active; the block itself does not enforce this.
module power_iteration_eigenvalue #(
    parameter int MAX_ORDER = 16,
    parameter int FRAC_BITS = 16
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     cfg_we,
    input  logic [1:0]               cfg_index,
    input  logic [pie_pkg::CFG_W-1:0] cfg_data,
    input  logic                     cmd_valid,
    output logic                     cmd_ready,
    input  logic [1:0]               op,
    input  logic [3:0]               row,
    input  logic [3:0]               col,
    input  logic signed [31:0]       value,
    output logic                     res_valid,
    input  logic                     res_ready,
    output logic                     is_eigenvalue,
    output logic [3:0]               index,
    output logic signed [31:0]       result_value,
    output logic [1:0]               status,
    output logic                     last
);
    import pie_pkg::*;

    localparam int IDX_W = $clog2(MAX_ORDER);
    localparam int NW    = $clog2(MAX_ORDER + 1);
    localparam int SUM_W = 64 - FRAC_BITS + IDX_W + 1;
    localparam int XW    = ((IDX_W > 4) ? IDX_W : 4) + 1;
    localparam logic [DATA_W-1:0] ONE_FIX = DATA_W'(64'd1 << FRAC_BITS);
    localparam logic signed [SUM_W-1:0] SUM_MAX = SUM_W'(64'sd2147483647);
    localparam logic signed [SUM_W-1:0] SUM_MIN = -SUM_MAX - SUM_W'(1);

    state_t state_reg, state_next;

    logic [ORDER_W-1:0] order_reg;
    logic [TOL_W-1:0]   tol_reg;
    logic [PASS_W-1:0]  max_passes_reg;

    logic [NW-1:0]     n_reg, n_next;
    logic [NW-1:0]     cnt_reg, cnt_next;
    logic [NW-1:0]     exit_cnt_reg, exit_cnt_next;
    logic [DATA_W-1:0] lam_reg, lam_next;
    logic [DATA_W-1:0] prev_reg, prev_next;
    logic [PASS_W-1:0] pass_reg, pass_next;
    logic [1:0]        status_reg, status_next;
    logic              div_busy_reg, div_busy_next;

    logic              res_valid_reg, res_valid_next;
    logic              res_eig_reg, res_eig_next;
    logic [3:0]        res_idx_reg, res_idx_next;
    logic [DATA_W-1:0] res_val_reg, res_val_next;
    logic [1:0]        res_status_reg, res_status_next;
    logic              res_last_reg, res_last_next;

    logic                    tok_valid [MAX_ORDER+1];
    logic [IDX_W-1:0]        tok_row   [MAX_ORDER+1];
    logic signed [SUM_W-1:0] tok_sum   [MAX_ORDER+1];
    logic [DATA_W-1:0]       cur_arr   [MAX_ORDER];
    logic [DATA_W-1:0]       prod_arr  [MAX_ORDER];

    logic              cmd_acc;
    logic [XW-1:0]     row_x, col_x;
    logic              row_ok, col_ok;
    logic [DATA_W-1:0] ex_sat, ex_abs;
    logic signed [SUM_W-1:0] ex_sum;
    logic              zero_fill;
    logic signed [DATA_W:0] diff;
    logic [DATA_W:0]   diff_abs;
    logic [PASS_W-1:0] cap;
    logic [7:0]        ord8;
    logic [NW-1:0]     emit_elem;
    div_req_t          div_req;
    logic              div_done;
    logic [DATA_W-1:0] div_quo;

    assign cmd_ready = (state_reg == S_IDLE);
    assign cmd_acc   = cmd_valid && cmd_ready;
    assign row_x     = XW'(row);
    assign col_x     = XW'(col);
    assign row_ok    = row_x < XW'(MAX_ORDER);
    assign col_ok    = col_x < XW'(MAX_ORDER);
    assign zero_fill = (state_reg == S_CHECK) && (lam_reg == '0);

    // Row tokens enter the head of the chain one per cycle.
    assign tok_valid[0] = (state_reg == S_INJECT);
    assign tok_row[0]   = cnt_reg[IDX_W-1:0];
    assign tok_sum[0]   = '0;

    for (genvar j = 0; j < MAX_ORDER; j++)
    begin : g_cell
        cell_wr_t wr;

        always_comb
        begin
            wr.mat_we    = cmd_acc && (op == OP_LOAD_MATRIX) && row_ok && col_ok
                           && (col_x == XW'(j));
            wr.mat_data  = value;
            wr.prod_we   = tok_valid[MAX_ORDER] && (tok_row[MAX_ORDER] == IDX_W'(j));
            wr.prod_data = ex_sat;
            wr.vec_we    = 1'b0;
            wr.vec_data  = value;
            if (cmd_acc && (op == OP_LOAD_VECTOR) && row_ok && (row_x == XW'(j)))
            begin
                wr.vec_we = 1'b1;
            end
            else if (zero_fill && (NW'(j) < n_reg))
            begin
                wr.vec_we   = 1'b1;
                wr.vec_data = '0;
            end
            else if (div_done && (cnt_reg[IDX_W-1:0] == IDX_W'(j)))
            begin
                wr.vec_we   = 1'b1;
                wr.vec_data = div_quo;
            end
        end

        pie_cell #(.MAX_ORDER(MAX_ORDER), .FRAC_BITS(FRAC_BITS)) u_cell (
            .clk           (clk),
            .rst_n         (rst_n),
            .wr            (wr),
            .mat_addr      (IDX_W'(row)),
            .active        (NW'(j) < n_reg),
            .tok_valid_in  (tok_valid[j]),
            .tok_row_in    (tok_row[j]),
            .tok_sum_in    (tok_sum[j]),
            .tok_valid_out (tok_valid[j+1]),
            .tok_row_out   (tok_row[j+1]),
            .tok_sum_out   (tok_sum[j+1]),
            .cur           (cur_arr[j]),
            .prod          (prod_arr[j])
        );
    end

    pie_div #(.FRAC_BITS(FRAC_BITS)) u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .done  (div_done),
        .quo   (div_quo)
    );

    always_comb
    begin
        ex_sum = tok_sum[MAX_ORDER];
        if (ex_sum > SUM_MAX)
        begin
            ex_sat = 32'h7FFF_FFFF;
        end
        else if (ex_sum < SUM_MIN)
        begin
            ex_sat = 32'h8000_0000;
        end
        else
        begin
            ex_sat = ex_sum[DATA_W-1:0];
        end
        if (!ex_sat[DATA_W-1])
        begin
            ex_abs = ex_sat;
        end
        else if (ex_sat == 32'h8000_0000)
        begin
            ex_abs = 32'h7FFF_FFFF;
        end
        else
        begin
            ex_abs = DATA_W'(-ex_sat);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            order_reg      <= ORDER_RESET;
            tol_reg        <= TOLERANCE_RESET;
            max_passes_reg <= MAX_PASSES_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_ORDER:      order_reg      <= cfg_data[ORDER_W-1:0];
                REG_TOLERANCE:  tol_reg        <= cfg_data[TOL_W-1:0];
                REG_MAX_PASSES: max_passes_reg <= cfg_data[PASS_W-1:0];
                default:        ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            n_reg         <= '0;
            cnt_reg       <= '0;
            exit_cnt_reg  <= '0;
            prev_reg      <= ONE_FIX;
            pass_reg      <= '0;
            status_reg    <= STATUS_CONVERGED;
            div_busy_reg  <= 1'b0;
            res_valid_reg <= 1'b0;
            lam_reg       <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            n_reg         <= n_next;
            cnt_reg       <= cnt_next;
            exit_cnt_reg  <= exit_cnt_next;
            prev_reg      <= prev_next;
            pass_reg      <= pass_next;
            status_reg    <= status_next;
            div_busy_reg  <= div_busy_next;
            res_valid_reg <= res_valid_next;
            lam_reg       <= lam_next;
        end
    end

    always_ff @(posedge clk)
    begin
        res_eig_reg    <= res_eig_next;
        res_idx_reg    <= res_idx_next;
        res_val_reg    <= res_val_next;
        res_status_reg <= res_status_next;
        res_last_reg   <= res_last_next;
    end

    always_comb
    begin
        state_next      = state_reg;
        n_next          = n_reg;
        cnt_next        = cnt_reg;
        exit_cnt_next   = exit_cnt_reg;
        lam_next        = lam_reg;
        prev_next       = prev_reg;
        pass_next       = pass_reg;
        status_next     = status_reg;
        div_busy_next   = div_busy_reg;
        res_valid_next  = res_valid_reg && !res_ready;
        res_eig_next    = res_eig_reg;
        res_idx_next    = res_idx_reg;
        res_val_next    = res_val_reg;
        res_status_next = res_status_reg;
        res_last_next   = res_last_reg;
        div_req.start   = 1'b0;
        div_req.num     = prod_arr[cnt_reg[IDX_W-1:0]];
        div_req.den     = lam_reg;
        ord8            = 8'(order_reg);
        cap             = (max_passes_reg == '0) ? PASS_W'(1) : max_passes_reg;
        diff            = $signed({1'b0, lam_reg}) - $signed({1'b0, prev_reg});
        diff_abs        = diff[DATA_W] ? (DATA_W+1)'(-diff) : diff;
        emit_elem       = cnt_reg - NW'(1);

        case (state_reg)
            S_IDLE:
            begin
                if (cmd_acc && (op == OP_START))
                begin
                    if (ord8 == 8'd0)
                    begin
                        n_next = NW'(1);
                    end
                    else if (ord8 > 8'(MAX_ORDER))
                    begin
                        n_next = NW'(MAX_ORDER);
                    end
                    else
                    begin
                        n_next = NW'(order_reg);
                    end
                    prev_next     = ONE_FIX;
                    pass_next     = '0;
                    cnt_next      = '0;
                    exit_cnt_next = '0;
                    lam_next      = '0;
                    state_next    = S_INJECT;
                end
            end
            S_INJECT:
            begin
                cnt_next = cnt_reg + NW'(1);
                if (cnt_reg == n_reg - NW'(1))
                begin
                    state_next = S_DRAIN;
                end
            end
            S_DRAIN:
            begin
                if (tok_valid[MAX_ORDER])
                begin
                    exit_cnt_next = exit_cnt_reg + NW'(1);
                    if (ex_abs > lam_reg)
                    begin
                        lam_next = ex_abs;
                    end
                    if (exit_cnt_reg == n_reg - NW'(1))
                    begin
                        state_next = S_CHECK;
                    end
                end
            end
            S_CHECK:
            begin
                pass_next = pass_reg + PASS_W'(1);
                cnt_next  = '0;
                if (lam_reg == '0)
                begin
                    // The cells clear their vector elements in this cycle.
                    status_next = STATUS_ZERO;
                    state_next  = S_EMIT;
                end
                else
                begin
                    div_busy_next = 1'b0;
                    state_next    = S_DIV;
                end
            end
            S_DIV:
            begin
                if (!div_busy_reg)
                begin
                    div_req.start = 1'b1;
                    div_busy_next = 1'b1;
                end
                else if (div_done)
                begin
                    div_busy_next = 1'b0;
                    cnt_next      = cnt_reg + NW'(1);
                    if (cnt_reg == n_reg - NW'(1))
                    begin
                        state_next = S_DECIDE;
                    end
                end
            end
            S_DECIDE:
            begin
                cnt_next      = '0;
                exit_cnt_next = '0;
                if (diff_abs <= {2'b00, tol_reg})
                begin
                    status_next = STATUS_CONVERGED;
                    state_next  = S_EMIT;
                end
                else
                begin
                    prev_next = lam_reg;
                    if (pass_reg >= cap)
                    begin
                        status_next = STATUS_PASS_LIMIT;
                        state_next  = S_EMIT;
                    end
                    else
                    begin
                        lam_next   = '0;
                        state_next = S_INJECT;
                    end
                end
            end
            S_EMIT:
            begin
                if (!res_valid_reg || res_ready)
                begin
                    res_valid_next  = 1'b1;
                    res_status_next = status_reg;
                    if (cnt_reg == '0)
                    begin
                        res_eig_next  = 1'b1;
                        res_idx_next  = '0;
                        res_val_next  = lam_reg;
                        res_last_next = 1'b0;
                    end
                    else
                    begin
                        res_eig_next  = 1'b0;
                        res_idx_next  = 4'(emit_elem);
                        res_val_next  = cur_arr[emit_elem[IDX_W-1:0]];
                        res_last_next = (cnt_reg == n_reg);
                    end
                    cnt_next = cnt_reg + NW'(1);
                    if (cnt_reg == n_reg)
                    begin
                        state_next = S_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign res_valid     = res_valid_reg;
    assign is_eigenvalue = res_eig_reg;
    assign index         = res_idx_reg;
    assign result_value  = res_val_reg;
    assign status        = res_status_reg;
    assign last          = res_last_reg;

    a_exit_in_drain: assert property (@(posedge clk) disable iff (!rst_n)
        tok_valid[MAX_ORDER] |-> (state_reg == S_DRAIN))
        else $error("row token left the chain outside the drain step");

    a_div_in_div: assert property (@(posedge clk) disable iff (!rst_n)
        div_done |-> (state_reg == S_DIV && div_busy_reg))
        else $error("division finished outside the divide step");

    a_emit_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_EMIT) |-> (cnt_reg <= n_reg))
        else $error("emit count ran past the order");

    a_order_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != S_IDLE) |-> (n_reg != '0 && n_reg <= NW'(MAX_ORDER)))
        else $error("order in use out of range during a run");

endmodule
